FILE: rtl/shdt_pkg.sv
// ============================================================================
// shdt_pkg
// shared types, constants and helpers of the soft/hard delimiter tokenizer
// ============================================================================
`default_nettype none

package shdt_pkg;

    localparam int MAX_INPUT_LENGTH = 65536;
    localparam int CAP_INT = ((MAX_INPUT_LENGTH - 1) < 65535) ? (MAX_INPUT_LENGTH - 1) : 65535;
    localparam logic [15:0] COUNT_CAP = 16'(CAP_INT);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_SOFT_SET_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOFT_SET_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SOFT_SET_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SOFT_SET_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HARD_SET_0 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HARD_SET_1 = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HARD_SET_2 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_HARD_SET_3 = 3'd7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_AW      = 2;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 56;

    typedef enum logic [1:0] {
        CL_TOK  = 2'd0,
        CL_SOFT = 2'd1,
        CL_HARD = 2'd2
    } byte_class_t;

    typedef enum logic [3:0] {
        SS_LEAD  = 4'b0001,
        SS_TOKEN = 4'b0010,
        SS_DHEAD = 4'b0100,
        SS_DTAIL = 4'b1000
    } scan_state_t;

    typedef struct packed {
        byte_class_t cls;
        logic        last;
    } q_item_t;

    typedef struct packed {
        logic        final_token;
        logic        trailing_is_hard;
        logic        trailing_has_soft;
        logic        previous_is_hard;
        logic        previous_has_soft;
        logic [15:0] delimiter_length;
        logic [15:0] token_length;
        logic [15:0] token_offset;
    } result_t;

    typedef struct packed {
        logic            item_pop;
        logic [OUT_AW:0] out_count;
    } back_status_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v < COUNT_CAP) ? v + 16'd1 : COUNT_CAP;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/shdt_front.sv
// ============================================================================
// shdt_front
// delimiter mask registers and per-byte classification
// ============================================================================
`default_nettype none

module shdt_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [shdt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [shdt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic [7:0]                      byte_value,
    input  wire logic                            last_byte,
    output shdt_pkg::q_item_t                    item
);
    import shdt_pkg::*;

    logic [255:0] soft_mask_reg;
    logic [255:0] hard_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            soft_mask_reg <= '0;
            hard_mask_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SOFT_SET_0: soft_mask_reg[63:0]    <= cfg_wdata;
                REG_SOFT_SET_1: soft_mask_reg[127:64]  <= cfg_wdata;
                REG_SOFT_SET_2: soft_mask_reg[191:128] <= cfg_wdata;
                REG_SOFT_SET_3: soft_mask_reg[255:192] <= cfg_wdata;
                REG_HARD_SET_0: hard_mask_reg[63:0]    <= cfg_wdata;
                REG_HARD_SET_1: hard_mask_reg[127:64]  <= cfg_wdata;
                REG_HARD_SET_2: hard_mask_reg[191:128] <= cfg_wdata;
                REG_HARD_SET_3: hard_mask_reg[255:192] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // hard wins over soft
    always_comb begin
        item.last = last_byte;
        if (hard_mask_reg[byte_value]) begin
            item.cls = CL_HARD;
        end else if (soft_mask_reg[byte_value]) begin
            item.cls = CL_SOFT;
        end else begin
            item.cls = CL_TOK;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/shdt_queue.sv
// ============================================================================
// shdt_queue
// short queue of classified bytes between front and back
// ============================================================================
`default_nettype none

module shdt_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire shdt_pkg::q_item_t push_item,
    output logic             full,
    input  wire logic        pop,
    output logic             valid,
    output shdt_pkg::q_item_t head_item
);
    import shdt_pkg::*;

    q_item_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW:0]     count_next;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign valid     = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/shdt_back.sv
// ============================================================================
// shdt_back
// scan state machine, token bookkeeping and result queue
// ============================================================================
`default_nettype none

module shdt_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_valid,
    input  wire shdt_pkg::q_item_t            q_item,
    output logic                              q_pop,
    output shdt_pkg::back_status_t            status,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [shdt_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);
    import shdt_pkg::*;

    scan_state_t state_reg, state_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] dlen_reg, dlen_next;
    logic        cur_soft_reg, cur_soft_next;
    logic        cur_hard_reg, cur_hard_next;
    logic        prev_soft_reg, prev_soft_next;
    logic        prev_hard_reg, prev_hard_next;

    logic        emit_first;
    logic        emit_second;
    logic        stop;
    result_t     res_first;
    result_t     res_second;

    result_t           out_mem_reg [OUT_DEPTH];
    logic [OUT_AW-1:0] out_wr_reg;
    logic [OUT_AW-1:0] out_rd_reg;
    logic [OUT_AW:0]   out_count_reg;
    logic [OUT_AW:0]   out_count_next;
    logic [1:0]        push_count;
    logic              out_pop;
    result_t           head;

    assign q_pop = q_valid && (out_count_reg <= (OUT_AW+1)'(OUT_DEPTH - 2));
    assign status.item_pop  = q_pop;
    assign status.out_count = out_count_reg;

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        len_next       = len_reg;
        dlen_next      = dlen_reg;
        cur_soft_next  = cur_soft_reg;
        cur_hard_next  = cur_hard_reg;
        prev_soft_next = prev_soft_reg;
        prev_hard_next = prev_hard_reg;
        emit_first     = 1'b0;
        emit_second    = 1'b0;
        stop           = 1'b0;
        res_first      = '0;
        res_second     = '0;

        if (q_pop) begin
            if (state_reg == SS_LEAD && q_item.cls == CL_SOFT) begin
                prev_soft_next = 1'b1;
                pos_next       = sat_inc(pos_reg);
            end else begin
                if (state_reg == SS_LEAD) begin
                    prev_hard_next = 1'b0;
                    start_next     = pos_reg;
                    len_next       = '0;
                    dlen_next      = '0;
                    cur_soft_next  = 1'b0;
                    cur_hard_next  = 1'b0;
                    state_next     = SS_TOKEN;
                end

                stop = (q_item.cls == CL_TOK && state_next != SS_TOKEN) ||
                       (q_item.cls == CL_HARD && state_next == SS_DTAIL);

                if (stop) begin
                    emit_first                  = 1'b1;
                    res_first.token_offset      = start_next;
                    res_first.token_length      = len_next;
                    res_first.delimiter_length  = dlen_next;
                    res_first.previous_has_soft = prev_soft_next;
                    res_first.previous_is_hard  = prev_hard_next;
                    res_first.trailing_has_soft = cur_soft_next;
                    res_first.trailing_is_hard  = cur_hard_next;
                    res_first.final_token       = 1'b0;
                    prev_soft_next = cur_soft_next;
                    prev_hard_next = cur_hard_next;
                    start_next     = pos_reg;
                    len_next       = '0;
                    dlen_next      = '0;
                    cur_soft_next  = 1'b0;
                    cur_hard_next  = 1'b0;
                    state_next     = SS_TOKEN;
                end

                case (q_item.cls)
                    CL_TOK: begin
                        len_next   = sat_inc(len_next);
                        state_next = SS_TOKEN;
                    end
                    CL_SOFT: begin
                        dlen_next     = sat_inc(dlen_next);
                        cur_soft_next = 1'b1;
                        state_next    = (state_next == SS_DTAIL) ? SS_DTAIL : SS_DHEAD;
                    end
                    CL_HARD: begin
                        dlen_next     = sat_inc(dlen_next);
                        cur_hard_next = 1'b1;
                        state_next    = SS_DTAIL;
                    end
                    default: begin
                        len_next   = sat_inc(len_next);
                        state_next = SS_TOKEN;
                    end
                endcase

                pos_next = sat_inc(pos_reg);

                if (q_item.last) begin
                    emit_second                  = 1'b1;
                    res_second.token_offset      = start_next;
                    res_second.token_length      = len_next;
                    res_second.delimiter_length  = dlen_next;
                    res_second.previous_has_soft = prev_soft_next;
                    res_second.previous_is_hard  = prev_hard_next;
                    res_second.trailing_has_soft = cur_soft_next;
                    res_second.trailing_is_hard  = cur_hard_next;
                    res_second.final_token       = 1'b1;
                end
            end

            // end of string brings everything back to the start
            if (q_item.last) begin
                state_next     = SS_LEAD;
                pos_next       = '0;
                start_next     = '0;
                len_next       = '0;
                dlen_next      = '0;
                cur_soft_next  = 1'b0;
                cur_hard_next  = 1'b0;
                prev_soft_next = 1'b0;
                prev_hard_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SS_LEAD;
            pos_reg       <= '0;
            start_reg     <= '0;
            len_reg       <= '0;
            dlen_reg      <= '0;
            cur_soft_reg  <= 1'b0;
            cur_hard_reg  <= 1'b0;
            prev_soft_reg <= 1'b0;
            prev_hard_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            len_reg       <= len_next;
            dlen_reg      <= dlen_next;
            cur_soft_reg  <= cur_soft_next;
            cur_hard_reg  <= cur_hard_next;
            prev_soft_reg <= prev_soft_next;
            prev_hard_reg <= prev_hard_next;
        end
    end

    // result queue, up to two writes per cycle
    assign push_count = {1'b0, emit_first} + {1'b0, emit_second};
    assign m_tvalid   = (out_count_reg != '0);
    assign out_pop    = m_tvalid && m_tready;
    assign head       = out_mem_reg[out_rd_reg];

    always_comb begin
        out_count_next = out_count_reg + (OUT_AW+1)'(push_count);
        if (out_pop) begin
            out_count_next = out_count_next - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_first) begin
            out_mem_reg[out_wr_reg] <= res_first;
            if (emit_second) begin
                out_mem_reg[out_wr_reg + 1'b1] <= res_second;
            end
        end else if (emit_second) begin
            out_mem_reg[out_wr_reg] <= res_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end else begin
            out_wr_reg    <= out_wr_reg + OUT_AW'(push_count);
            if (out_pop) begin
                out_rd_reg <= out_rd_reg + 1'b1;
            end
            out_count_reg <= out_count_next;
        end
    end

    assign m_tdata = {4'b0000,
                      head.trailing_is_hard,
                      head.trailing_has_soft,
                      head.previous_is_hard,
                      head.previous_has_soft,
                      head.delimiter_length,
                      head.token_length,
                      head.token_offset};
    assign m_tlast = head.final_token;

endmodule

`default_nettype wire

FILE: rtl/soft_hard_delimiter_tokenizer_top.sv
// ============================================================================
// soft_hard_delimiter_tokenizer_top
// splits a byte stream into tokens using soft and hard delimiter masks
// ============================================================================
// One byte is accepted per cycle while the byte queue has room. The front
// classes each byte against the soft and hard masks into a four-entry byte
// queue; the back runs the scan state machine on one queued byte per cycle
// while the result queue has room for two, writing results to a four-entry
// result queue, where they are valid on the master side. A closing byte that
// is also the last byte of a string gives two results, so the sustained rate
// is one byte per cycle as long as the output takes one result per cycle.
// Mask registers are written through the cfg port while no string is in
// flight; the user is bound to this, the block itself does not enforce it.
`default_nettype none

module soft_hard_delimiter_tokenizer_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [shdt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [shdt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [shdt_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] byte_value
    input  wire logic                             s_tlast,   // last_byte
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [15:0] token_offset, [31:16] token_length, [47:32] delimiter_length,
    // [48] previous_has_soft, [49] previous_is_hard, [50] trailing_has_soft,
    // [51] trailing_is_hard, [55:52] zero
    output logic [shdt_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tlast    // final_token
);
    import shdt_pkg::*;

    q_item_t      front_item;
    q_item_t      head_item;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    logic         q_push;
    back_status_t back_status;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    shdt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .byte_value (s_tdata),
        .last_byte  (s_tlast),
        .item       (front_item)
    );

    shdt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_item (head_item)
    );

    shdt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .status   (back_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_reset_empties_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_pop_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.item_pop |-> (back_status.out_count <= 3'(OUT_DEPTH - 2)))
        else $error("byte taken without room for two results");

    a_no_result_without_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (back_status.out_count == '0 && !back_status.item_pop) |=> !m_tvalid)
        else $error("result appeared with no byte processed");

endmodule

`default_nettype wire

FILE: verif/soft_hard_delimiter_tokenizer_top_tb.sv
// ============================================================================
// soft_hard_delimiter_tokenizer_top_tb
// self-checking testbench of the soft/hard delimiter tokenizer
// ============================================================================
// Bytes go in on the slave stream and token records come back on the master
// stream. A behavioral tokenizer in the bench tracks the scan state and the
// delimiter masks and queues the token records that each accepted byte
// closes. Every record on the master side is compared field by field with
// the oldest queued one. A short directed table covers reset masks, hard over
// soft, skipped leading soft delimiters, empty tokens, all-soft strings and
// closing bytes that end the string. Random strings follow under a series of
// mask settings, from all clear to all set. The last part runs without idling
// and includes long runs of token and soft bytes.
// ============================================================================

module soft_hard_delimiter_tokenizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import shdt_pkg::*;

    localparam real CLK_PERIOD   = 12.0;
    localparam int  RESET_CYCLES = 5;
    localparam int  DRAIN_CYCLES = 12;
    localparam int  QUIET_LIMIT  = 2000;
    localparam int  PHASE_ITEMS  = 88;
    localparam int  TAIL_ITEMS   = 80;
    localparam int  LONG_RUN     = 16;
    localparam int  DIR_ROWS     = 21;
    localparam int  DIR_CFG_ROW  = 2;

    typedef logic [3:0][63:0] mask_set_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       typed;
        result_t    want;
    } dir_row_t;

    localparam logic [3:0][CFG_INDEX_W-1:0] SOFT_REGS =
        {REG_SOFT_SET_3, REG_SOFT_SET_2, REG_SOFT_SET_1, REG_SOFT_SET_0};
    localparam logic [3:0][CFG_INDEX_W-1:0] HARD_REGS =
        {REG_HARD_SET_3, REG_HARD_SET_2, REG_HARD_SET_1, REG_HARD_SET_0};

    // space soft, comma hard, 0xff both (hard wins)
    localparam mask_set_t DIR_SOFT =
        {64'h8000_0000_0000_0000, 64'h0, 64'h0, 64'h0000_0001_0000_0000};
    localparam mask_set_t DIR_HARD =
        {64'h8000_0000_0000_0000, 64'h0, 64'h0, 64'h0000_1000_0000_0000};

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    logic    idle_en      = 1'b1;
    int      stall_left   = 0;
    int      quiet_cycles = 0;
    int      mismatches   = 0;
    int      bytes_sent   = 0;
    result_t pending_tokens [$];

    // tokenizer state of the bench
    mask_set_t   soft_mask = '0;
    mask_set_t   hard_mask = '0;
    scan_state_t scan      = SS_LEAD;
    logic [15:0] pos       = '0;
    logic [15:0] tok_start = '0;
    logic [15:0] tok_len   = '0;
    logic [15:0] delim_len = '0;
    logic        trail_soft = 1'b0;
    logic        trail_hard = 1'b0;
    logic        prev_soft  = 1'b0;
    logic        prev_hard  = 1'b0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, '{final_token: 1'b1, token_length: 16'd1, default: '0}},
        '{8'hff, 1'b1, 1'b1, '{final_token: 1'b1, token_length: 16'd1, default: '0}},
        '{8'h20, 1'b0, 1'b0, '0},
        '{8'h20, 1'b0, 1'b0, '0},
        '{8'h61, 1'b0, 1'b0, '0},
        '{8'h62, 1'b0, 1'b0, '0},
        '{8'h20, 1'b0, 1'b0, '0},
        '{8'h2c, 1'b0, 1'b0, '0},
        '{8'h2c, 1'b0, 1'b0, '0},
        '{8'h20, 1'b0, 1'b0, '0},
        '{8'h63, 1'b0, 1'b0, '0},
        '{8'hff, 1'b0, 1'b0, '0},
        '{8'h20, 1'b1, 1'b0, '0},
        '{8'h20, 1'b0, 1'b0, '0},
        '{8'h20, 1'b1, 1'b0, '0},
        '{8'h2c, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h2c, 1'b0, 1'b0, '0},
        '{8'h79, 1'b1, 1'b0, '0},
        '{8'h2c, 1'b0, 1'b0, '0},
        '{8'h2c, 1'b1, 1'b0, '0}
    };

    soft_hard_delimiter_tokenizer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    function automatic logic [15:0] count_up(input logic [15:0] v);
        return (v == COUNT_CAP) ? v : v + 16'd1;
    endfunction

    function automatic byte_class_t class_of_byte(input logic [7:0] value);
        if (hard_mask[value[7:6]][value[5:0]]) return CL_HARD;
        if (soft_mask[value[7:6]][value[5:0]]) return CL_SOFT;
        return CL_TOK;
    endfunction

    function automatic logic [7:0] pick_byte(input byte_class_t want);
        logic [7:0] b;
        b = 8'($urandom);
        for (int k = 0; k < 64 && class_of_byte(b) != want; k++) b = 8'($urandom);
        return b;
    endfunction

    function automatic mask_set_t random_lanes(input int ands);
        mask_set_t m;
        for (int k = 0; k < 4; k++) begin
            m[k] = '1;
            for (int j = 0; j < ands; j++) m[k] = m[k] & {$urandom, $urandom};
        end
        return m;
    endfunction

    task automatic clear_scan();
        scan       = SS_LEAD;
        pos        = '0;
        tok_start  = '0;
        tok_len    = '0;
        delim_len  = '0;
        trail_soft = 1'b0;
        trail_hard = 1'b0;
        prev_soft  = 1'b0;
        prev_hard  = 1'b0;
    endtask

    task automatic open_token();
        tok_start  = pos;
        tok_len    = '0;
        delim_len  = '0;
        trail_soft = 1'b0;
        trail_hard = 1'b0;
        scan       = SS_TOKEN;
    endtask

    task automatic push_token(input logic fin);
        result_t r;
        r.token_offset      = tok_start;
        r.token_length      = tok_len;
        r.delimiter_length  = delim_len;
        r.previous_has_soft = prev_soft;
        r.previous_is_hard  = prev_hard;
        r.trailing_has_soft = trail_soft;
        r.trailing_is_hard  = trail_hard;
        r.final_token       = fin;
        pending_tokens.push_back(r);
    endtask

    task automatic tokenize_byte(input logic [7:0] value, input logic last);
        byte_class_t cls;
        cls = class_of_byte(value);
        if (scan == SS_LEAD && cls == CL_SOFT) begin
            prev_soft = 1'b1;
            pos = count_up(pos);
        end else begin
            if (scan == SS_LEAD) begin
                prev_hard = 1'b0;
                open_token();
            end
            // a token byte after delimiters, or a second hard one, closes the token
            if ((cls == CL_TOK && scan != SS_TOKEN) || (cls == CL_HARD && scan == SS_DTAIL)) begin
                push_token(1'b0);
                prev_soft = trail_soft;
                prev_hard = trail_hard;
                open_token();
            end
            case (cls)
                CL_TOK: begin
                    tok_len = count_up(tok_len);
                end
                CL_SOFT: begin
                    delim_len  = count_up(delim_len);
                    trail_soft = 1'b1;
                    if (scan != SS_DTAIL) scan = SS_DHEAD;
                end
                default: begin
                    delim_len  = count_up(delim_len);
                    trail_hard = 1'b1;
                    scan       = SS_DTAIL;
                end
            endcase
            pos = count_up(pos);
            if (last) push_token(1'b1);
        end
        if (last) clear_scan();
    endtask

    task automatic send_byte(input logic [7:0] value, input logic last);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        tokenize_byte(value, last);
        bytes_sent++;
    endtask

    task automatic send_random_string(input int max_len);
        int         len;
        int         pick;
        logic       noise;
        logic [7:0] b;
        len   = $urandom_range(1, max_len);
        noise = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 9);
            if (noise) b = 8'($urandom);
            else if (pick < 5) b = pick_byte(CL_TOK);
            else if (pick < 8) b = pick_byte(CL_SOFT);
            else b = pick_byte(CL_HARD);
            send_byte(b, k == len - 1);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_masks(input mask_set_t soft_v, input mask_set_t hard_v);
        for (int k = 0; k < 4; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= SOFT_REGS[k];
            cfg_wdata <= soft_v[k];
            @(posedge aclk);
            cfg_index <= HARD_REGS[k];
            cfg_wdata <= hard_v[k];
            @(posedge aclk);
        end
        cfg_we    <= 1'b0;
        soft_mask = soft_v;
        hard_mask = hard_v;
    endtask

    // result side: check each transfer, random stall bursts on tready
    always @(posedge aclk) begin : token_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tokens.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected token transfer: tdata=%h tlast=%b", m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = pending_tokens.pop_front();
                if (m_tdata[15:0] !== want.token_offset || m_tdata[31:16] !== want.token_length
                        || m_tdata[47:32] !== want.delimiter_length
                        || m_tdata[48] !== want.previous_has_soft
                        || m_tdata[49] !== want.previous_is_hard
                        || m_tdata[50] !== want.trailing_has_soft
                        || m_tdata[51] !== want.trailing_is_hard
                        || m_tdata[55:52] !== 4'd0 || m_tlast !== want.final_token) begin
                    if (mismatches < 10) begin
                        $write("token mismatch: expected off=%0d len=%0d delim=%0d ",
                               want.token_offset, want.token_length, want.delimiter_length);
                        $write("prev=%b%b trail=%b%b final=%b, ",
                               want.previous_has_soft, want.previous_is_hard,
                               want.trailing_has_soft, want.trailing_is_hard,
                               want.final_token);
                        $display("got off=%0d len=%0d delim=%0d prev=%b%b trail=%b%b final=%b pad=%h",
                                 m_tdata[15:0], m_tdata[31:16],
                                 m_tdata[47:32], m_tdata[48], m_tdata[49], m_tdata[50],
                                 m_tdata[51], m_tlast, m_tdata[55:52]);
                    end
                    mismatches++;
                end
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!idle_en) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int start;
        mask_set_t soft_v;
        mask_set_t hard_v;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == DIR_CFG_ROW) begin
                settle();
                program_masks(DIR_SOFT, DIR_HARD);
            end
            send_byte(dir_rows[i].value, dir_rows[i].last);
            if (dir_rows[i].typed) begin
                void'(pending_tokens.pop_back());
                pending_tokens.push_back(dir_rows[i].want);
            end
        end

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    soft_v = random_lanes(2);
                    hard_v = random_lanes(3);
                end
                1: begin
                    soft_v = '1;
                    hard_v = '1;
                end
                2: begin
                    soft_v = '1;
                    hard_v = '0;
                end
                3: begin
                    soft_v = '0;
                    hard_v = '0;
                end
                4: begin
                    soft_v = random_lanes(1);
                    hard_v = random_lanes(4);
                end
                5: begin
                    soft_v = '0;
                    hard_v = random_lanes(2);
                end
                6: begin
                    soft_v = random_lanes(2);
                    hard_v = '0;
                end
                default: begin
                    soft_v = random_lanes(3);
                    hard_v = random_lanes(1);
                end
            endcase
            settle();
            program_masks(soft_v, hard_v);
            start = bytes_sent;
            while (bytes_sent - start < PHASE_ITEMS) send_random_string(14);
        end

        // no idling from here on; long runs of one class
        settle();
        idle_en = 1'b0;
        program_masks(DIR_SOFT, DIR_HARD);
        for (int k = 0; k < LONG_RUN; k++) send_byte(8'h61, 1'b0);
        send_byte(8'h2c, 1'b0);
        send_byte(8'h62, 1'b1);
        for (int k = 0; k < LONG_RUN; k++) send_byte(8'h20, 1'b0);
        send_byte(8'h61, 1'b0);
        for (int k = 0; k < LONG_RUN; k++) send_byte(8'h20, k == LONG_RUN - 1);

        settle();
        program_masks(random_lanes(2), random_lanes(3));
        start = bytes_sent;
        while (bytes_sent - start < TAIL_ITEMS) send_random_string(14);

        settle();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/shdt_pkg.sv
rtl/shdt_front.sv
rtl/shdt_queue.sv
rtl/shdt_back.sv
rtl/soft_hard_delimiter_tokenizer_top.sv
verif/soft_hard_delimiter_tokenizer_top_tb.sv
